// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion sampled on clk, switched off while rst is high
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion sampled on clk, also checked across reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mlmt_pkg.sv
// types, constants and codes of the modulator list merge table
package mlmt_pkg;

   localparam int CAPACITY      = 64;
   localparam int IDX_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W         = $clog2(CAPACITY + 1);
   localparam int FIELD_W       = 16;
   localparam int KEY_W         = 4 * FIELD_W;
   localparam int CMD_W         = 2;
   localparam int READ_INDEX_W  = 6;
   localparam int STATUS_W      = 3;
   localparam int INDEX_OUT_W   = 6;
   localparam int COUNT_OUT_W   = 7;

   // fill count of a full table
   localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

   // depth of the job queue between front and back
   localparam int JOB_DEPTH     = 2;
   localparam int JOB_PTR_W     = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
   localparam int JOB_CNT_W     = $clog2(JOB_DEPTH + 1);

   // command codes of the input beat
   localparam logic [CMD_W-1:0] CMD_KEEP  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

   typedef enum logic [STATUS_W-1:0] {
      STS_APPENDED   = 3'd0,
      STS_DUPLICATE  = 3'd1,
      STS_ADDED      = 3'd2,
      STS_FULL       = 3'd3,
      STS_READ_OK    = 3'd4,
      STS_READ_RANGE = 3'd5,
      STS_CLEARED    = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      OP_KEEP,
      OP_ADD,
      OP_READ,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic [FIELD_W-1:0]      source_operator;
      logic [FIELD_W-1:0]      destination;
      logic signed [FIELD_W-1:0] amount;
      logic [FIELD_W-1:0]      amount_source_operator;
      logic [FIELD_W-1:0]      transform;
      logic [READ_INDEX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [INDEX_OUT_W-1:0]  entry_index;
      logic [COUNT_OUT_W-1:0]  entry_count;
      logic [FIELD_W-1:0]      out_source_operator;
      logic [FIELD_W-1:0]      out_destination;
      logic signed [FIELD_W-1:0] out_amount;
      logic [FIELD_W-1:0]      out_amount_source_operator;
      logic [FIELD_W-1:0]      out_transform;
      logic                    sum_overflow;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      op_type                  op;
      logic [KEY_W-1:0]        key;
      logic signed [FIELD_W-1:0] amount;
      logic [READ_INDEX_W-1:0] read_index;
   } job_type;

   // handshake between front queue and back engine
   typedef struct packed {
      logic valid;
   } job_stat_type;

   typedef struct packed {
      logic pop;
   } job_ctrl_type;

endpackage

// File: rtl/modulator_list_merge_table.sv
// top level of the modulator list merge table
//
//  channel | ports                          | beat
//  --------+--------------------------------+-------------------------------
//  request | req_push, req_full, req_data   | push & !full, one command
//  result  | rsp_empty, rsp_pop, rsp_data   | pop & !empty, one result
//
// an insert on an empty table appends straight from idle, otherwise it scans:
// the key memory's single registered read port compares one stored entry a cycle
// a read addresses the memory, then answers from the registered data; a clear
// answers straight from idle; every beat passes through the two-deep front queue
// synchronous reset empties the queue, the result register and the fill count;
// table memories are not cleared, entries past the fill count are never read
// the back end starts an item only when the result register is free or popped
module modulator_list_merge_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  mlmt_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output mlmt_pkg::rsp_type rsp_data
);
   import mlmt_pkg::*;

   // classified items waiting between front and back
   job_type      job_head;
   job_stat_type job_stat;
   job_ctrl_type job_ctrl;

   // front: decodes the command, packs the 64-bit key, queues the beat
   mlmt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .job_head (job_head),
      .job_stat (job_stat),
      .job_ctrl (job_ctrl)
   );

   // back: scans the table, updates it and holds the result until popped
   mlmt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_head  (job_head),
      .job_stat  (job_stat),
      .job_ctrl  (job_ctrl),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/mlmt_front.sv
// front end: accepts request beats, classifies them, holds them in a two-deep queue
module mlmt_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  mlmt_pkg::req_type     req_data,
   output mlmt_pkg::job_type     job_head,
   output mlmt_pkg::job_stat_type job_stat,
   input  mlmt_pkg::job_ctrl_type job_ctrl
);
   import mlmt_pkg::*;

   job_type              slot_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0] count_ff, count_in;
   job_type              job_new;
   logic                 push_ok;
   logic                 pop_ok;

   // classify the command and pack the match key
   always_comb begin
      job_new.key        = {req_data.source_operator, req_data.destination,
                            req_data.amount_source_operator, req_data.transform};
      job_new.amount     = req_data.amount;
      job_new.read_index = req_data.read_index;
      case (req_data.command)
         CMD_KEEP:  job_new.op = OP_KEEP;
         CMD_ADD:   job_new.op = OP_ADD;
         CMD_READ:  job_new.op = OP_READ;
         CMD_CLEAR: job_new.op = OP_CLEAR;
         default:   job_new.op = OP_KEEP;
      endcase
   end

   assign req_full       = (count_ff == JOB_CNT_W'(JOB_DEPTH));
   assign job_stat.valid = (count_ff != '0);
   assign job_head       = slot_ff[rd_ptr_ff];
   assign push_ok        = req_push && !req_full;
   assign pop_ok         = job_ctrl.pop && job_stat.valid;

   // pointers wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0
                                                              : JOB_PTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == JOB_PTR_W'(JOB_DEPTH - 1)) ? '0
                                                              : JOB_PTR_W'(rd_ptr_ff + 1'b1);
      end
      count_in  = count_ff + JOB_CNT_W'(push_ok) - JOB_CNT_W'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= job_new;
      end
   end

endmodule

// File: rtl/mlmt_back.sv
// back end: table memories, key scan engine and result register
module mlmt_back (
   input  logic                   clock,
   input  logic                   reset,
   input  mlmt_pkg::job_type      job_head,
   input  mlmt_pkg::job_stat_type job_stat,
   output mlmt_pkg::job_ctrl_type job_ctrl,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output mlmt_pkg::rsp_type      rsp_data
);
   import mlmt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SCAN  = 3'b010,
      S_RDATA = 3'b100
   } state_type;

   logic [KEY_W-1:0]          key_mem [CAPACITY];
   logic signed [FIELD_W-1:0] amt_mem [CAPACITY];

   state_type                 state_ff, state_in;
   job_type                   job_ff, job_in;
   logic [IDX_W-1:0]          cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]          fill_ff, fill_in;
   rsp_type                   rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]          rd_key_ff;
   logic signed [FIELD_W-1:0] rd_amt_ff;

   logic [IDX_W-1:0]          rd_addr;
   logic                      key_we, amt_we;
   logic [IDX_W-1:0]          key_waddr, amt_waddr;
   logic signed [FIELD_W-1:0] amt_wdata;
   job_type                   cur;
   logic                      slot_free;
   logic                      key_hit;
   logic                      last_entry;
   logic                      has_room;
   logic signed [FIELD_W:0]   sum;
   logic                      sum_ovf;

   function automatic rsp_type make_rsp(status_type st, logic [31:0] idx, logic [31:0] cnt,
                                        logic [KEY_W-1:0] key,
                                        logic signed [FIELD_W-1:0] amt, logic ovf);
      rsp_type r;
      r.status                     = st;
      r.entry_index                = idx[INDEX_OUT_W-1:0];
      r.entry_count                = cnt[COUNT_OUT_W-1:0];
      r.out_source_operator        = key[4*FIELD_W-1:3*FIELD_W];
      r.out_destination            = key[3*FIELD_W-1:2*FIELD_W];
      r.out_amount                 = amt;
      r.out_amount_source_operator = key[2*FIELD_W-1:FIELD_W];
      r.out_transform              = key[FIELD_W-1:0];
      r.sum_overflow               = ovf;
      return r;
   endfunction

   assign slot_free    = !rsp_valid_ff || rsp_pop;
   assign job_ctrl.pop = (state_ff == S_IDLE) && job_stat.valid && slot_free;
   assign cur          = (state_ff == S_IDLE) ? job_head : job_ff;
   assign key_hit      = (rd_key_ff == job_ff.key);
   assign last_entry   = (32'(cmp_idx_ff) + 32'd1 == 32'(fill_ff));
   assign has_room     = (fill_ff < CAP_COUNT);
   assign sum          = (FIELD_W+1)'(rd_amt_ff) + (FIELD_W+1)'(job_ff.amount);
   assign sum_ovf      = sum[FIELD_W] ^ sum[FIELD_W-1];
   assign rsp_empty    = !rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      cmp_idx_in   = cmp_idx_ff;
      fill_in      = fill_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rd_addr      = cmp_idx_ff;
      key_we       = 1'b0;
      amt_we       = 1'b0;
      key_waddr    = IDX_W'(fill_ff);
      amt_waddr    = IDX_W'(fill_ff);
      amt_wdata    = cur.amount;

      case (state_ff)
         S_IDLE: begin
            if (job_ctrl.pop) begin
               job_in = job_head;
               case (job_head.op)
                  OP_CLEAR: begin
                     fill_in      = '0;
                     rsp_in       = make_rsp(STS_CLEARED, 32'd0, 32'd0, '0, '0, 1'b0);
                     rsp_valid_in = 1'b1;
                  end
                  OP_READ: begin
                     if (32'(job_head.read_index) < 32'(fill_ff)) begin
                        rd_addr  = IDX_W'(job_head.read_index);
                        state_in = S_RDATA;
                     end else begin
                        rsp_in = make_rsp(STS_READ_RANGE, 32'(job_head.read_index),
                                          32'(fill_ff), '0, '0, 1'b0);
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_KEEP, OP_ADD: begin
                     if (fill_ff == '0) begin
                        // empty table: append straight away
                        key_we       = 1'b1;
                        amt_we       = 1'b1;
                        fill_in      = CNT_W'(fill_ff + 1'b1);
                        rsp_in       = make_rsp(STS_APPENDED, 32'(fill_ff),
                                                32'(fill_ff) + 32'd1, cur.key, cur.amount, 1'b0);
                        rsp_valid_in = 1'b1;
                     end else begin
                        rd_addr    = '0;
                        cmp_idx_in = '0;
                        state_in   = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_RDATA: begin
            rsp_in       = make_rsp(STS_READ_OK, 32'(job_ff.read_index), 32'(fill_ff),
                                    rd_key_ff, rd_amt_ff, 1'b0);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_SCAN: begin
            if (key_hit) begin
               if (job_ff.op == OP_ADD) begin
                  amt_we    = 1'b1;
                  amt_waddr = cmp_idx_ff;
                  amt_wdata = sum[FIELD_W-1:0];
                  rsp_in    = make_rsp(STS_ADDED, 32'(cmp_idx_ff), 32'(fill_ff),
                                       job_ff.key, sum[FIELD_W-1:0], sum_ovf);
               end else begin
                  rsp_in = make_rsp(STS_DUPLICATE, 32'(cmp_idx_ff), 32'(fill_ff),
                                    job_ff.key, rd_amt_ff, 1'b0);
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (last_entry) begin
               if (has_room) begin
                  key_we  = 1'b1;
                  amt_we  = 1'b1;
                  fill_in = CNT_W'(fill_ff + 1'b1);
                  rsp_in  = make_rsp(STS_APPENDED, 32'(fill_ff), 32'(fill_ff) + 32'd1,
                                     job_ff.key, job_ff.amount, 1'b0);
               end else begin
                  rsp_in = make_rsp(STS_FULL, 32'd0, 32'(fill_ff),
                                    job_ff.key, job_ff.amount, 1'b0);
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cmp_idx_in = IDX_W'(cmp_idx_ff + 1'b1);
               rd_addr    = cmp_idx_in;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      cmp_idx_ff <= cmp_idx_in;
      rsp_ff     <= rsp_in;
   end

   // table memories: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= cur.key;
      end
      if (amt_we) begin
         amt_mem[amt_waddr] <= amt_wdata;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_amt_ff <= amt_mem[rd_addr];
   end

endmodule

// File: rtl/mlmt_checker.sv
// port-level checks of the merge table, bound to the top level
`include "assert_macros.svh"

module mlmt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input mlmt_pkg::rsp_type rsp_data
);
   import mlmt_pkg::*;

   // the result side comes out of reset empty and the request side not full
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty && !req_full, "not empty after reset")

   // a waiting result beat holds until popped
   `ASSERT_SYNC(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data), "result beat changed while stalled")

   // two appends in a row raise the count by one
   `ASSERT_SYNC(a_append_count, clock, reset, (!rsp_empty && rsp_pop && rsp_data.status == STS_APPENDED) ##1 (!rsp_empty && rsp_data.status == STS_APPENDED) |-> rsp_data.entry_count == COUNT_OUT_W'($past(rsp_data.entry_count) + 1'b1), "append count did not step")

   // overflow is only flagged on an add
   `ASSERT_SYNC(a_ovf_add, clock, reset, !rsp_empty && rsp_data.sum_overflow |-> rsp_data.status == STS_ADDED, "overflow without add")

endmodule

bind modulator_list_merge_table mlmt_checker u_mlmt_checker (.*);

// File: bench/tb.sv
`timescale 1ns / 100ps
// self-checking bench for the modulator list merge table
module tb;
   import mlmt_pkg::*;

   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 12;
   // worst case per beat is a full table scan plus queue and pop stalls,
   // taken several times over for roughly two thousand beats
   localparam int LIMIT = 1_200_000;
   localparam int SETTLE = 100;
   localparam int CHUNKS = 20;
   localparam int CHUNK_BEATS = 94;
   localparam int POOL = 96;

   // one row of the directed table; reps > 1 walks the destination and amount
   typedef struct {
      req_type     req;
      int unsigned reps;
      bit          typed;
      rsp_type     want;
   } plan_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   // shadow copy of the table contents
   logic [KEY_W-1:0]   shadow_key [CAPACITY];
   logic [FIELD_W-1:0] shadow_amount [CAPACITY];
   int unsigned        shadow_fill = 0;

   rsp_type          pending_results [$];
   rsp_type          head;
   int unsigned      err_count = 0;
   int unsigned      cycle_count = 0;
   int unsigned      send_idle_pct = 0;
   int unsigned      pop_stall_pct = 0;
   logic [KEY_W-1:0] key_pool [POOL];
   plan_row_type     plan [$];

   modulator_list_merge_table i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // append a row to the directed table
   function automatic void plan_add(plan_row_type row);
      plan.insert(plan.size(), row);
   endfunction

   // append an expectation behind the ones already waiting
   function automatic void expect_add(rsp_type o);
      pending_results.insert(pending_results.size(), o);
   endfunction

   // what the table answers to one command, updating the shadow copy
   function automatic rsp_type table_outcome(req_type r);
      rsp_type          o;
      logic [KEY_W-1:0] k;
      logic [FIELD_W:0] sum;
      int               hit;
      o = '0;
      k = {r.source_operator, r.destination, r.amount_source_operator, r.transform};
      hit = -1;
      case (r.command)
         CMD_CLEAR: begin
            // entries stay in place but drop out of reach
            shadow_fill = 0;
            o.status = STS_CLEARED;
         end
         CMD_READ: begin
            o.entry_index = r.read_index;
            if (r.read_index < shadow_fill) begin
               o.status = STS_READ_OK;
               {o.out_source_operator, o.out_destination,
                o.out_amount_source_operator, o.out_transform} = shadow_key[r.read_index];
               o.out_amount = shadow_amount[r.read_index];
            end else begin
               o.status = STS_READ_RANGE;
            end
         end
         default: begin
            // lowest matching position wins
            for (int i = 0; i < shadow_fill; i++)
               if (hit < 0 && shadow_key[i] == k) hit = i;
            if (hit >= 0) begin
               if (r.command == CMD_ADD) begin
                  // 17-bit sum, overflow when the top two bits disagree
                  sum = {shadow_amount[hit][FIELD_W-1], shadow_amount[hit]}
                        + {r.amount[FIELD_W-1], r.amount};
                  o.sum_overflow = sum[FIELD_W] ^ sum[FIELD_W-1];
                  shadow_amount[hit] = sum[FIELD_W-1:0];
                  o.status = STS_ADDED;
               end else begin
                  o.status = STS_DUPLICATE;
               end
               o.entry_index = INDEX_OUT_W'(hit);
               o.out_amount = shadow_amount[hit];
            end else if (shadow_fill < CAPACITY) begin
               o.entry_index = INDEX_OUT_W'(shadow_fill);
               shadow_key[shadow_fill] = k;
               shadow_amount[shadow_fill] = r.amount;
               shadow_fill++;
               o.status = STS_APPENDED;
               o.out_amount = r.amount;
            end else begin
               // full table: dropped record is echoed at index zero
               o.status = STS_FULL;
               o.out_amount = r.amount;
            end
            {o.out_source_operator, o.out_destination,
             o.out_amount_source_operator, o.out_transform} = k;
         end
      endcase
      o.entry_count = COUNT_OUT_W'(shadow_fill);
      return o;
   endfunction

   function automatic req_type mk_req(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] k,
                                      logic [FIELD_W-1:0] amt,
                                      logic [READ_INDEX_W-1:0] ridx);
      req_type r;
      r.command = cmd;
      {r.source_operator, r.destination, r.amount_source_operator, r.transform} = k;
      r.amount = amt;
      r.read_index = ridx;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(status_type s, logic [INDEX_OUT_W-1:0] idx,
                                      logic [COUNT_OUT_W-1:0] cnt, logic [KEY_W-1:0] k,
                                      logic [FIELD_W-1:0] amt, logic ovf);
      rsp_type o;
      o.status = s;
      o.entry_index = idx;
      o.entry_count = cnt;
      {o.out_source_operator, o.out_destination,
       o.out_amount_source_operator, o.out_transform} = k;
      o.out_amount = amt;
      o.sum_overflow = ovf;
      return o;
   endfunction

   // mostly keys from a pool so that matches and a full table come about,
   // a tenth fresh keys, and every field filled with noise first
   function automatic req_type random_beat(int unsigned span, int unsigned clear_pct);
      req_type          r;
      logic [95:0]      noise;
      logic [KEY_W-1:0] k;
      int unsigned      pick;
      noise = {$urandom, $urandom, $urandom};
      r = noise[$bits(req_type)-1:0];
      pick = $urandom_range(99);
      if (pick < clear_pct) r.command = CMD_CLEAR;
      else if (pick < 30) r.command = CMD_KEEP;
      else if (pick < 65) r.command = CMD_ADD;
      else r.command = CMD_READ;
      if (r.command == CMD_KEEP || r.command == CMD_ADD) begin
         k = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                      : key_pool[$urandom_range(span - 1)];
         {r.source_operator, r.destination, r.amount_source_operator, r.transform} = k;
         case ($urandom_range(7))
            0: r.amount = 16'h7FFF;
            1: r.amount = 16'h8000;
            2: r.amount = 16'hFFFF;
            3: r.amount = 16'h0001;
            default: ;
         endcase
      end else if (r.command == CMD_READ && $urandom_range(1) == 1) begin
         // aim half the reads at the filled range and the position just past it
         r.read_index = READ_INDEX_W'($urandom_range((shadow_fill < 64) ? shadow_fill : 63));
      end
      return r;
   endfunction

   function automatic void field_check(string name, logic [FIELD_W-1:0] want,
                                       logic [FIELD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         err_count++;
      end
   endfunction

   // one request beat: random idle first, then hold push until accepted
   task automatic send_beat(input req_type r, input bit typed, input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_data <= r;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predicted = table_outcome(r);
      expect_add(typed ? want : predicted);
   endtask

   // hold off the sender until every outstanding result has come back
   task automatic wait_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // result side: pop with random stalls, compare each beat with the oldest
   // expectation; values are read before this edge's updates land
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_results.size() == 0) begin
            $error("result beat with nothing expected");
            err_count++;
         end else begin
            head = pending_results.pop_front();
            field_check("status", head.status, rsp_data.status);
            field_check("entry_index", head.entry_index, rsp_data.entry_index);
            field_check("entry_count", head.entry_count, rsp_data.entry_count);
            field_check("out_source_operator", head.out_source_operator,
                        rsp_data.out_source_operator);
            field_check("out_destination", head.out_destination, rsp_data.out_destination);
            field_check("out_amount", head.out_amount, rsp_data.out_amount);
            field_check("out_amount_source_operator", head.out_amount_source_operator,
                        rsp_data.out_amount_source_operator);
            field_check("out_transform", head.out_transform, rsp_data.out_transform);
            field_check("sum_overflow", head.sum_overflow, rsp_data.sum_overflow);
         end
      end
      rsp_pop <= !reset && ($urandom_range(99) >= pop_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      req_type     r;
      int unsigned span;
      int unsigned clear_pct;

      for (int i = 0; i < POOL; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = {4{16'h8001}};
      key_pool[3] = 64'h1;

      // directed table: empty reads, extreme keys and amounts, both overflow
      // directions, a fill to capacity, matches while full and a clear
      plan_add('{mk_req(CMD_READ, '0, 16'h0000, 6'd0), 1, 1'b1,
                 mk_rsp(STS_READ_RANGE, 6'd0, 7'd0, '0, 16'h0000, 1'b0)});
      plan_add('{mk_req(CMD_CLEAR, '1, 16'hFFFF, 6'd63), 1, 1'b1,
                 mk_rsp(STS_CLEARED, 6'd0, 7'd0, '0, 16'h0000, 1'b0)});
      plan_add('{mk_req(CMD_KEEP, '0, 16'h7FFF, 6'd0), 1, 1'b1,
                 mk_rsp(STS_APPENDED, 6'd0, 7'd1, '0, 16'h7FFF, 1'b0)});
      plan_add('{mk_req(CMD_KEEP, '1, 16'h8000, 6'd63), 1, 1'b1,
                 mk_rsp(STS_APPENDED, 6'd1, 7'd2, '1, 16'h8000, 1'b0)});
      plan_add('{mk_req(CMD_KEEP, '0, 16'h0005, 6'd0), 1, 1'b1,
                 mk_rsp(STS_DUPLICATE, 6'd0, 7'd2, '0, 16'h7FFF, 1'b0)});
      // positive wrap, then negative wrap, then a sum that stays in range
      plan_add('{mk_req(CMD_ADD, '0, 16'h0001, 6'd0), 1, 1'b1,
                 mk_rsp(STS_ADDED, 6'd0, 7'd2, '0, 16'h8000, 1'b1)});
      plan_add('{mk_req(CMD_ADD, '1, 16'hFFFF, 6'd0), 1, 1'b1,
                 mk_rsp(STS_ADDED, 6'd1, 7'd2, '1, 16'h7FFF, 1'b1)});
      plan_add('{mk_req(CMD_ADD, '0, 16'h7FFF, 6'd0), 1, 1'b1,
                 mk_rsp(STS_ADDED, 6'd0, 7'd2, '0, 16'hFFFF, 1'b0)});
      plan_add('{mk_req(CMD_ADD, 64'h0123_4567_89AB_CDEF, 16'h0064, 6'd0), 1, 1'b0,
                 '0});
      plan_add('{mk_req(CMD_READ, '0, 16'h0000, 6'd1), 1, 1'b1,
                 mk_rsp(STS_READ_OK, 6'd1, 7'd3, '1, 16'h7FFF, 1'b0)});
      plan_add('{mk_req(CMD_READ, '0, 16'h0000, 6'd3), 1, 1'b1,
                 mk_rsp(STS_READ_RANGE, 6'd3, 7'd3, '0, 16'h0000, 1'b0)});
      plan_add('{mk_req(CMD_READ, '1, 16'hFFFF, 6'd63), 1, 1'b1,
                 mk_rsp(STS_READ_RANGE, 6'd63, 7'd3, '0, 16'h0000, 1'b0)});
      // differs from the all-zero key in a single bit
      plan_add('{mk_req(CMD_KEEP, 64'h1, 16'h4000, 6'd0), 1, 1'b0, '0});
      // sixty distinct keys bring the table to capacity
      plan_add('{mk_req(CMD_KEEP, 64'h5A5A_0000_A5A5_00FF, 16'h0100, 6'd0), 60, 1'b0,
                 '0});
      plan_add('{mk_req(CMD_KEEP, 64'hFFFF_0000_FFFF_0000, 16'h1234, 6'd0), 1, 1'b1,
                 mk_rsp(STS_FULL, 6'd0, 7'd64, 64'hFFFF_0000_FFFF_0000, 16'h1234,
                        1'b0)});
      plan_add('{mk_req(CMD_ADD, '1, 16'h0001, 6'd0), 1, 1'b1,
                 mk_rsp(STS_ADDED, 6'd1, 7'd64, '1, 16'h8000, 1'b1)});
      plan_add('{mk_req(CMD_KEEP, '0, 16'h2222, 6'd0), 1, 1'b1,
                 mk_rsp(STS_DUPLICATE, 6'd0, 7'd64, '0, 16'hFFFF, 1'b0)});
      plan_add('{mk_req(CMD_ADD, 64'h1, 16'h8000, 6'd0), 1, 1'b0, '0});
      plan_add('{mk_req(CMD_READ, '0, 16'h0000, 6'd63), 1, 1'b0, '0});
      plan_add('{mk_req(CMD_CLEAR, '1, 16'h7FFF, 6'd42), 1, 1'b1,
                 mk_rsp(STS_CLEARED, 6'd0, 7'd0, '0, 16'h0000, 1'b0)});
      plan_add('{mk_req(CMD_READ, '0, 16'h0000, 6'd0), 1, 1'b1,
                 mk_rsp(STS_READ_RANGE, 6'd0, 7'd0, '0, 16'h0000, 1'b0)});
      plan_add('{mk_req(CMD_ADD, 64'hDEAD_BEEF_0BAD_F00D, 16'hFFFF, 6'd0), 1, 1'b0,
                 '0});

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed beats, back to back
      foreach (plan[n]) begin
         for (int k = 0; k < plan[n].reps; k++) begin
            r = plan[n].req;
            r.destination = r.destination + FIELD_W'(k);
            r.amount = r.amount + FIELD_W'(k);
            send_beat(r, plan[n].typed, plan[n].want);
         end
      end

      // random beats in chunks; each chunk picks an idling mode, a key pool
      // span (small for many matches, wide for a full table) and a clear rate
      for (int c = 0; c < CHUNKS; c++) begin
         case (c % 5)
            0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            1: begin send_idle_pct = 54; pop_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  pop_stall_pct = 54; end
            3: begin send_idle_pct = 7;  pop_stall_pct = 7;  end
            default: begin send_idle_pct = 0; pop_stall_pct = 0; end
         endcase
         span = (c % 4 == 0) ? 8 : (c % 4 == 1) ? 40 : (c % 4 == 2) ? 72 : POOL;
         clear_pct = (c % 3 == 0) ? 1 : 5;
         repeat (CHUNK_BEATS) send_beat(random_beat(span, clear_pct), 1'b0, '0);
         // sender holds off until the block has gone quiet
         if (c % 4 == 3) wait_drained();
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (err_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
